// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Checked property, also evaluated while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== design/shg_pkg.sv =====
package shg_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam logic [30:0] CELL_SIZE_RST = 31'd65536;

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_SLOT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_RANGE = 2'd1,
        KIND_SLOT  = 2'd2
    } t_kind;

    // Request as it travels from the front to the back: coordinates are cell indices.
    typedef struct packed {
        t_op         op;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [31:0] iz;
        logic        last;
        logic [9:0]  slot;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_LOAD,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_QUERY,
        PH_COUNT,
        PH_SCATTER
    } t_phase;

    typedef enum logic [4:0] {
        B_CLEAR,
        B_IDLE,
        B_H0,
        B_H1,
        B_H2,
        B_H3,
        B_MOD,
        B_LWR,
        B_BGN,
        B_ZERO,
        B_HRD,
        B_HLD,
        B_CRD,
        B_CWR,
        B_PRD,
        B_PWR,
        B_SRD,
        B_SWR,
        B_DONE,
        B_QRD,
        B_QEM,
        B_SLRD,
        B_SLEM
    } t_bstate;

endpackage

// ===== design/shg_fifo.sv =====
module shg_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  shg_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output shg_pkg::t_cmd o_data
);

    shg_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/shg_front.sv =====
module shg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [30:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_opcode,
    input  logic [31:0]   i_pos_x,
    input  logic [31:0]   i_pos_y,
    input  logic [31:0]   i_pos_z,
    input  logic          i_last_particle,
    input  logic [9:0]    i_slot,
    input  logic          i_hold,
    output logic          o_push,
    output shg_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    shg_pkg::t_fstate r_state;
    shg_pkg::t_fstate n_state;
    shg_pkg::t_cmd    r_cmd;
    shg_pkg::t_cmd    n_cmd;
    logic [30:0]      r_cell;
    logic [31:0]      r_num;
    logic [31:0]      n_num;
    logic [30:0]      r_rem;
    logic [30:0]      n_rem;
    logic [4:0]       r_bit;
    logic [4:0]       n_bit;
    logic [1:0]       r_c;
    logic [1:0]       n_c;
    logic             r_neg;
    logic             n_neg;

    logic             accept;
    logic [31:0]      raw;
    logic [30:0]      divisor;
    logic [31:0]      sh;
    logic             ge;
    logic [30:0]      rem_nx;
    logic [31:0]      quo_nx;
    logic [31:0]      coord;

    assign o_stall = (r_state != shg_pkg::F_IDLE) || i_hold;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;
    assign o_push  = (r_state == shg_pkg::F_PUSH);

    always_comb begin
        case (r_c)
            2'd0:    raw = r_cmd.ix;
            2'd1:    raw = r_cmd.iy;
            default: raw = r_cmd.iz;
        endcase
        divisor = (r_cell == 31'd0) ? 31'd1 : r_cell;
        sh      = {r_rem, r_num[31]};
        ge      = (sh >= {1'b0, divisor});
        rem_nx  = ge ? 31'(sh - {1'b0, divisor}) : sh[30:0];
        quo_nx  = {r_num[30:0], ge};
        // floor for negative dividends: -q, or -q-1 when a remainder is left
        if (r_neg) begin
            coord = (rem_nx != 31'd0) ? ~quo_nx : 32'(-quo_nx);
        end else begin
            coord = quo_nx;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shg_pkg::F_IDLE: begin
                if (accept) begin
                    case (shg_pkg::t_op'(i_opcode))
                        shg_pkg::OP_LOAD, shg_pkg::OP_QUERY: n_state = shg_pkg::F_LOAD;
                        shg_pkg::OP_SLOT:                    n_state = shg_pkg::F_PUSH;
                        default:                             n_state = shg_pkg::F_IDLE;
                    endcase
                end
            end
            shg_pkg::F_LOAD: n_state = shg_pkg::F_DIV;
            shg_pkg::F_DIV: begin
                if (r_bit == 5'd0) begin
                    n_state = (r_c == 2'd2) ? shg_pkg::F_PUSH : shg_pkg::F_LOAD;
                end
            end
            shg_pkg::F_PUSH: begin
                if (!i_full) begin
                    n_state = shg_pkg::F_IDLE;
                end
            end
            default: n_state = shg_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd;
        n_num = r_num;
        n_rem = r_rem;
        n_bit = r_bit;
        n_c   = r_c;
        n_neg = r_neg;
        unique case (r_state)
            shg_pkg::F_IDLE: begin
                n_cmd.op   = shg_pkg::t_op'(i_opcode);
                n_cmd.ix   = i_pos_x;
                n_cmd.iy   = i_pos_y;
                n_cmd.iz   = i_pos_z;
                n_cmd.last = i_last_particle;
                n_cmd.slot = i_slot;
                n_c        = 2'd0;
            end
            shg_pkg::F_LOAD: begin
                n_neg = raw[31];
                n_num = raw[31] ? 32'(-raw) : raw;
                n_rem = 31'd0;
                n_bit = 5'd31;
            end
            shg_pkg::F_DIV: begin
                n_num = quo_nx;
                n_rem = rem_nx;
                n_bit = r_bit - 5'd1;
                if (r_bit == 5'd0) begin
                    case (r_c)
                        2'd0:    n_cmd.ix = coord;
                        2'd1:    n_cmd.iy = coord;
                        default: n_cmd.iz = coord;
                    endcase
                    n_c = r_c + 2'd1;
                end
            end
            shg_pkg::F_PUSH: begin
                n_cmd = r_cmd;
            end
            default: n_cmd = r_cmd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shg_pkg::F_IDLE;
            r_cell  <= shg_pkg::CELL_SIZE_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cell <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!(r_state == shg_pkg::F_IDLE && !accept)) begin
            r_cmd <= n_cmd;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_c   <= n_c;
        r_neg <= n_neg;
    end

endmodule

// ===== design/shg_back.sv =====
module shg_back #(
    parameter int MAX_PARTICLES = shg_pkg::MAX_PARTICLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_clearing,
    input  logic          i_empty,
    input  shg_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_kind,
    output logic [10:0]   o_bucket,
    output logic [10:0]   o_range_start,
    output logic [10:0]   o_range_count,
    output logic [9:0]    o_particle_index,
    output logic [10:0]   o_particle_total,
    output logic          o_overflow,
    output logic          o_last
);

    localparam int TBL = 2 * MAX_PARTICLES;
    localparam int AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int BW  = $clog2(TBL);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int TW  = CW + 1;

    // Storage
    logic [31:0]    hash_mem   [MAX_PARTICLES];
    logic [CW-1:0]  cnt_mem    [TBL];
    logic [CW-1:0]  start_mem  [TBL];
    logic [AW-1:0]  sorted_mem [MAX_PARTICLES];

    logic [31:0]    hash_rd;
    logic [CW-1:0]  cnt_rd;
    logic [CW-1:0]  start_rd;
    logic [AW-1:0]  sorted_rd;

    logic           hm_we;
    logic           cm_we;
    logic [BW-1:0]  cm_wa;
    logic [CW-1:0]  cm_wd;
    logic [BW-1:0]  cm_ra;
    logic           sm_we;
    logic [BW-1:0]  sm_wa;
    logic [CW-1:0]  sm_wd;
    logic           so_we;
    logic [AW-1:0]  so_wa;
    logic [AW-1:0]  so_ra;

    shg_pkg::t_bstate r_state;
    shg_pkg::t_bstate n_state;
    shg_pkg::t_phase  r_phase;
    shg_pkg::t_phase  n_phase;
    shg_pkg::t_cmd    r_cmd;
    shg_pkg::t_cmd    n_cmd;
    logic [31:0]      r_h;
    logic [31:0]      n_h;
    logic [31:0]      r_prod;
    logic [31:0]      n_prod;
    logic [TW-1:0]    r_rem;
    logic [TW-1:0]    n_rem;
    logic [4:0]       r_bit;
    logic [4:0]       n_bit;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    n_i;
    logic [TW-1:0]    r_j;
    logic [TW-1:0]    n_j;
    logic [CW-1:0]    r_run;
    logic [CW-1:0]    n_run;
    logic [CW-1:0]    r_load_cnt;
    logic [CW-1:0]    n_load_cnt;
    logic [CW-1:0]    r_total;
    logic [CW-1:0]    n_total;
    logic [TW-1:0]    r_table;
    logic [TW-1:0]    n_table;
    logic             r_drop;
    logic             n_drop;
    logic [BW-1:0]    r_bkt;
    logic [BW-1:0]    n_bkt;
    logic [1:0]       r_dx;
    logic [1:0]       n_dx;
    logic [1:0]       r_dy;
    logic [1:0]       n_dy;
    logic [1:0]       r_dz;
    logic [1:0]       n_dz;

    logic             r_ovalid;
    logic             n_ovalid;
    logic [1:0]       r_okind;
    logic [1:0]       n_okind;
    logic [10:0]      r_obucket;
    logic [10:0]      n_obucket;
    logic [10:0]      r_ostart;
    logic [10:0]      n_ostart;
    logic [10:0]      r_ocount;
    logic [10:0]      n_ocount;
    logic [9:0]       r_oindex;
    logic [9:0]       n_oindex;
    logic [10:0]      r_ototal;
    logic [10:0]      n_ototal;
    logic             r_oovf;
    logic             n_oovf;
    logic             r_olast;
    logic             n_olast;

    logic             out_free;
    logic             nb_last;
    logic [31:0]      cx;
    logic [31:0]      cy;
    logic [31:0]      cz;
    logic [31:0]      mul_a;
    logic [31:0]      mul_c;
    logic [63:0]      mul_full;
    logic [TW:0]      mod_sh;
    logic [TW-1:0]    rem_nx;
    logic [CW:0]      pos;

    assign o_clearing       = (r_state == shg_pkg::B_CLEAR);
    assign o_valid          = r_ovalid;
    assign o_kind           = r_okind;
    assign o_bucket         = r_obucket;
    assign o_range_start    = r_ostart;
    assign o_range_count    = r_ocount;
    assign o_particle_index = r_oindex;
    assign o_particle_total = r_ototal;
    assign o_overflow       = r_oovf;
    assign o_last           = r_olast;

    assign out_free = !r_ovalid || !i_stall;
    assign nb_last  = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);
    assign o_pop    = (r_state == shg_pkg::B_IDLE) && !i_empty;

    // Neighbor offsets are stored biased by one: 0,1,2 stand for -1,0,+1.
    assign cx = r_cmd.ix + {30'd0, r_dx} - 32'd1;
    assign cy = r_cmd.iy + {30'd0, r_dy} - 32'd1;
    assign cz = r_cmd.iz + {30'd0, r_dz} - 32'd1;

    always_comb begin
        case (r_state)
            shg_pkg::B_H0: begin
                mul_a = cx;
                mul_c = shg_pkg::HASH_PX;
            end
            shg_pkg::B_H1: begin
                mul_a = cy;
                mul_c = shg_pkg::HASH_PY;
            end
            default: begin
                mul_a = cz;
                mul_c = shg_pkg::HASH_PZ;
            end
        endcase
        mul_full = mul_a * mul_c;
        mod_sh   = {r_rem, r_h[r_bit]};
        rem_nx   = (mod_sh >= {1'b0, r_table}) ? TW'(mod_sh - {1'b0, r_table})
                                               : mod_sh[TW-1:0];
        pos      = {1'b0, start_rd} + {1'b0, cnt_rd};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shg_pkg::B_CLEAR: begin
                if (r_j == TW'(TBL - 1)) begin
                    n_state = shg_pkg::B_IDLE;
                end
            end
            shg_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_cmd.op == shg_pkg::OP_SLOT) ? shg_pkg::B_SLRD
                                                             : shg_pkg::B_H0;
                end
            end
            shg_pkg::B_H0:  n_state = shg_pkg::B_H1;
            shg_pkg::B_H1:  n_state = shg_pkg::B_H2;
            shg_pkg::B_H2:  n_state = shg_pkg::B_H3;
            shg_pkg::B_H3: begin
                n_state = (r_phase == shg_pkg::PH_LOAD) ? shg_pkg::B_LWR : shg_pkg::B_MOD;
            end
            shg_pkg::B_MOD: begin
                if (r_bit == 5'd0) begin
                    case (r_phase)
                        shg_pkg::PH_COUNT:   n_state = shg_pkg::B_CRD;
                        shg_pkg::PH_SCATTER: n_state = shg_pkg::B_SRD;
                        default:             n_state = shg_pkg::B_QRD;
                    endcase
                end
            end
            shg_pkg::B_LWR: begin
                n_state = r_cmd.last ? shg_pkg::B_BGN : shg_pkg::B_IDLE;
            end
            shg_pkg::B_BGN: n_state = shg_pkg::B_ZERO;
            shg_pkg::B_ZERO: begin
                if (r_j == r_table - TW'(1)) begin
                    n_state = shg_pkg::B_HRD;
                end
            end
            shg_pkg::B_HRD: begin
                if (r_i == r_load_cnt) begin
                    n_state = (r_phase == shg_pkg::PH_COUNT) ? shg_pkg::B_PRD
                                                             : shg_pkg::B_DONE;
                end else begin
                    n_state = shg_pkg::B_HLD;
                end
            end
            shg_pkg::B_HLD: n_state = shg_pkg::B_MOD;
            shg_pkg::B_CRD: n_state = shg_pkg::B_CWR;
            shg_pkg::B_CWR: n_state = shg_pkg::B_HRD;
            shg_pkg::B_PRD: n_state = shg_pkg::B_PWR;
            shg_pkg::B_PWR: begin
                n_state = (r_j == r_table - TW'(1)) ? shg_pkg::B_HRD : shg_pkg::B_PRD;
            end
            shg_pkg::B_SRD: n_state = shg_pkg::B_SWR;
            shg_pkg::B_SWR: n_state = shg_pkg::B_HRD;
            shg_pkg::B_DONE: begin
                if (out_free) begin
                    n_state = shg_pkg::B_IDLE;
                end
            end
            shg_pkg::B_QRD: n_state = shg_pkg::B_QEM;
            shg_pkg::B_QEM: begin
                if (out_free) begin
                    n_state = nb_last ? shg_pkg::B_IDLE : shg_pkg::B_H0;
                end
            end
            shg_pkg::B_SLRD: n_state = shg_pkg::B_SLEM;
            shg_pkg::B_SLEM: begin
                if (out_free) begin
                    n_state = shg_pkg::B_IDLE;
                end
            end
            default: n_state = shg_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_h        = r_h;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_i        = r_i;
        n_j        = r_j;
        n_run      = r_run;
        n_load_cnt = r_load_cnt;
        n_total    = r_total;
        n_table    = r_table;
        n_drop     = r_drop;
        n_bkt      = r_bkt;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_dz       = r_dz;
        n_ovalid   = r_ovalid && i_stall;
        n_okind    = r_okind;
        n_obucket  = r_obucket;
        n_ostart   = r_ostart;
        n_ocount   = r_ocount;
        n_oindex   = r_oindex;
        n_ototal   = r_ototal;
        n_oovf     = r_oovf;
        n_olast    = r_olast;
        hm_we      = 1'b0;
        cm_we      = 1'b0;
        cm_wa      = r_bkt;
        cm_wd      = CW'(cnt_rd + CW'(1));
        cm_ra      = r_bkt;
        sm_we      = 1'b0;
        sm_wa      = BW'(r_j);
        sm_wd      = r_run;
        so_we      = 1'b0;
        so_wa      = AW'(pos);
        so_ra      = AW'(r_cmd.slot);
        unique case (r_state)
            shg_pkg::B_CLEAR: begin
                cm_we = 1'b1;
                cm_wa = BW'(r_j);
                cm_wd = '0;
                sm_we = 1'b1;
                sm_wd = '0;
                n_j   = r_j + TW'(1);
            end
            shg_pkg::B_IDLE: begin
                n_cmd = i_cmd;
                if (i_cmd.op == shg_pkg::OP_LOAD) begin
                    n_phase = shg_pkg::PH_LOAD;
                    n_dx    = 2'd1;
                    n_dy    = 2'd1;
                    n_dz    = 2'd1;
                end else begin
                    n_phase = shg_pkg::PH_QUERY;
                    n_dx    = 2'd0;
                    n_dy    = 2'd0;
                    n_dz    = 2'd0;
                end
            end
            shg_pkg::B_H0: n_prod = mul_full[31:0];
            shg_pkg::B_H1: begin
                n_h    = r_prod;
                n_prod = mul_full[31:0];
            end
            shg_pkg::B_H2: begin
                n_h    = r_h ^ r_prod;
                n_prod = mul_full[31:0];
            end
            shg_pkg::B_H3: begin
                n_h   = r_h ^ r_prod;
                n_rem = '0;
                n_bit = 5'd31;
            end
            shg_pkg::B_MOD: begin
                n_rem = rem_nx;
                n_bit = r_bit - 5'd1;
                n_bkt = BW'(rem_nx);
            end
            shg_pkg::B_LWR: begin
                if (r_load_cnt < CW'(MAX_PARTICLES)) begin
                    hm_we      = 1'b1;
                    n_load_cnt = r_load_cnt + CW'(1);
                end else begin
                    n_drop = 1'b1;
                end
            end
            shg_pkg::B_BGN: begin
                n_table = (r_load_cnt == '0) ? TW'(TBL) : TW'({r_load_cnt, 1'b0});
                n_j     = '0;
                n_phase = shg_pkg::PH_COUNT;
            end
            shg_pkg::B_ZERO: begin
                cm_we = 1'b1;
                cm_wa = BW'(r_j);
                cm_wd = '0;
                n_j   = r_j + TW'(1);
                n_i   = '0;
            end
            shg_pkg::B_HRD: begin
                n_j   = '0;
                n_run = '0;
            end
            shg_pkg::B_HLD: begin
                n_h   = hash_rd;
                n_rem = '0;
                n_bit = 5'd31;
            end
            shg_pkg::B_CRD: begin
                cm_ra = r_bkt;
            end
            shg_pkg::B_CWR: begin
                cm_we = 1'b1;
                n_i   = r_i + CW'(1);
            end
            shg_pkg::B_PRD: begin
                cm_ra = BW'(r_j);
            end
            shg_pkg::B_PWR: begin
                cm_ra = BW'(r_j);
                sm_we = 1'b1;
                cm_we = 1'b1;
                cm_wa = BW'(r_j);
                cm_wd = '0;
                n_run = CW'(r_run + cnt_rd);
                n_j   = r_j + TW'(1);
                if (r_j == r_table - TW'(1)) begin
                    n_i     = '0;
                    n_phase = shg_pkg::PH_SCATTER;
                end
            end
            shg_pkg::B_SRD: begin
                cm_ra = r_bkt;
            end
            shg_pkg::B_SWR: begin
                so_we = (pos < (CW + 1)'(MAX_PARTICLES));
                cm_we = 1'b1;
                n_i   = r_i + CW'(1);
            end
            shg_pkg::B_DONE: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_okind    = shg_pkg::KIND_DONE;
                    n_obucket  = '0;
                    n_ostart   = '0;
                    n_ocount   = '0;
                    n_oindex   = '0;
                    n_ototal   = 11'(r_load_cnt);
                    n_oovf     = r_drop;
                    n_olast    = 1'b1;
                    n_total    = r_load_cnt;
                    n_load_cnt = '0;
                    n_drop     = 1'b0;
                end
            end
            shg_pkg::B_QRD: begin
                cm_ra = r_bkt;
            end
            shg_pkg::B_QEM: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = shg_pkg::KIND_RANGE;
                    n_obucket = 11'(r_bkt);
                    n_ostart  = 11'(start_rd);
                    n_ocount  = 11'(cnt_rd);
                    n_oindex  = '0;
                    n_ototal  = '0;
                    n_oovf    = 1'b0;
                    n_olast   = nb_last;
                    // dz runs fastest, dx slowest
                    if (r_dz == 2'd2) begin
                        n_dz = 2'd0;
                        if (r_dy == 2'd2) begin
                            n_dy = 2'd0;
                            n_dx = r_dx + 2'd1;
                        end else begin
                            n_dy = r_dy + 2'd1;
                        end
                    end else begin
                        n_dz = r_dz + 2'd1;
                    end
                end
            end
            shg_pkg::B_SLRD: begin
                so_ra = AW'(r_cmd.slot);
            end
            shg_pkg::B_SLEM: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = shg_pkg::KIND_SLOT;
                    n_obucket = '0;
                    n_ostart  = '0;
                    n_ocount  = '0;
                    n_oindex  = ({7'd0, r_cmd.slot} < 17'(r_total)) ? 10'(sorted_rd) : 10'd0;
                    n_ototal  = '0;
                    n_oovf    = 1'b0;
                    n_olast   = 1'b1;
                end
            end
            default: n_cmd = r_cmd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hm_we) begin
            hash_mem[AW'(r_load_cnt)] <= r_h;
        end
        hash_rd <= hash_mem[AW'(r_i)];
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            cnt_mem[cm_wa] <= cm_wd;
        end
        cnt_rd <= cnt_mem[cm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            start_mem[sm_wa] <= sm_wd;
        end
        start_rd <= start_mem[cm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (so_we) begin
            sorted_mem[so_wa] <= AW'(r_i);
        end
        sorted_rd <= sorted_mem[so_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shg_pkg::B_CLEAR;
            r_j        <= '0;
            r_load_cnt <= '0;
            r_total    <= '0;
            r_table    <= TW'(TBL);
            r_drop     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_j        <= n_j;
            r_load_cnt <= n_load_cnt;
            r_total    <= n_total;
            r_table    <= n_table;
            r_drop     <= n_drop;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_cmd     <= n_cmd;
        r_h       <= n_h;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_bit     <= n_bit;
        r_i       <= n_i;
        r_run     <= n_run;
        r_bkt     <= n_bkt;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_dz      <= n_dz;
        r_okind   <= n_okind;
        r_obucket <= n_obucket;
        r_ostart  <= n_ostart;
        r_ocount  <= n_ocount;
        r_oindex  <= n_oindex;
        r_ototal  <= n_ototal;
        r_oovf    <= n_oovf;
        r_olast   <= n_olast;
    end

endmodule

// ===== design/spatial_hash_grid_build_query_top.sv =====
// Spatial hash grid: loads gather particle positions, the load marked last builds a
// bucket-sorted table, queries return start and count for the 27 cells around a position,
// and slot reads return one sorted particle number. The front takes a request and, for
// loads and queries, runs three floor divisions by cell_size on one shared restoring
// divider at one bit per cycle. A two-entry queue feeds the back, which hashes with one
// shared multiplier and reduces a hash modulo the table size on a bit-serial unit. A
// query gives 27 results in all, one per neighbor cell. A build clears the counts,
// counts the particles per bucket, forms the bucket starts and scatters the particles
// into sorted order. After reset the back clears its bucket tables; no request is
// taken meanwhile, but configuration writes are.
module spatial_hash_grid_build_query_top #(
    parameter int MAX_PARTICLES = shg_pkg::MAX_PARTICLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic        i_last_particle,
    input  logic [9:0]  i_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [10:0] o_bucket,
    output logic [10:0] o_range_start,
    output logic [10:0] o_range_count,
    output logic [9:0]  o_particle_index,
    output logic [10:0] o_particle_total,
    output logic        o_overflow,
    output logic        o_last
);

    shg_pkg::t_cmd push_cmd;
    shg_pkg::t_cmd pop_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    logic          clearing;

    shg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_last_particle (i_last_particle),
        .i_slot          (i_slot),
        .i_hold          (clearing),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (full)
    );

    shg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_cmd)
    );

    shg_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .o_clearing       (clearing),
        .i_empty          (empty),
        .i_cmd            (pop_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_bucket         (o_bucket),
        .o_range_start    (o_range_start),
        .o_range_count    (o_range_count),
        .o_particle_index (o_particle_index),
        .o_particle_total (o_particle_total),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

endmodule

// ===== design/shg_checker.sv =====
`include "assert_macros.svh"

module shg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [10:0] o_bucket,
    input logic [10:0] o_range_count,
    input logic        o_last
);

    `ASSERT_CLK(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid)
    `ASSERT_CLK(a_single_last, i_clk, i_rst_n, o_valid && (o_kind == shg_pkg::KIND_DONE || o_kind == shg_pkg::KIND_SLOT) |-> o_last)
    `ASSERT_CLK(a_slot_clean, i_clk, i_rst_n, o_valid && o_kind == shg_pkg::KIND_SLOT |-> o_bucket == 11'd0 && o_range_count == 11'd0)

endmodule

bind spatial_hash_grid_build_query_top shg_checker u_shg_checker (.*);
